// ----- hdl/mxb_pkg.sv -----
// Shared constants, types and helpers for the maximum subset XOR basis core.
`default_nettype none
package mxb_pkg;

	// Number of basis slots, which is also the number of value bits that take part.
	localparam int WIDTH = 32;

	// Width of the value and result fields on the stream ports.
	localparam int FIELD_W = 32;

	typedef logic [WIDTH-1:0]   row_t;
	typedef logic [FIELD_W-1:0] field_t;

	// One element moving down the chain of cells.
	typedef struct packed {
		logic valid;  // a real element occupies this slot of the chain
		logic last;   // element closes its set
		row_t v;      // value, partly reduced by the cells it has passed
		row_t acc;    // running maximum, only meaningful when last is set
	} token_t;

	// Keep the low WIDTH bits of a stream field, filling with zeros above it.
	function automatic row_t field_to_row(input field_t f);
		logic [63:0] ext;
		ext = 64'(f);
		return ext[WIDTH-1:0];
	endfunction

	// Zero-extend or truncate a row to the result field.
	function automatic field_t row_to_field(input row_t r);
		logic [63:0] ext;
		ext = 64'(r);
		return ext[FIELD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/mxb_cell.sv -----
// One basis slot of the chain: reduces a passing element and folds the slot into the maximum.
`default_nettype none
module mxb_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,       // chain advances this cycle
	input  wire mxb_pkg::row_t  pos,      // one-hot mask of the bit this slot owns
	input  wire mxb_pkg::token_t tok_in,
	output mxb_pkg::token_t     tok_out
);

	mxb_pkg::row_t   row_q;
	mxb_pkg::row_t   row_new;
	mxb_pkg::token_t tok_next;
	logic            hit;
	logic            empty;

	always_comb begin
		hit      = |(tok_in.v & pos);
		empty    = (row_q == '0);
		row_new  = row_q;
		tok_next = tok_in;
		if (tok_in.valid && hit) begin
			if (empty) begin
				// The reduced value lands here and stops reducing further down.
				row_new    = tok_in.v;
				tok_next.v = '0;
			end else begin
				tok_next.v = tok_in.v ^ row_q;
			end
		end
		// Greedy step: taking this row helps exactly when the running result lacks this bit.
		if (tok_in.last && (row_new != '0) && !(|(tok_in.acc & pos))) begin
			tok_next.acc = tok_in.acc ^ row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (en && tok_in.valid) begin
			row_q <= tok_in.last ? '0 : row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (en) begin
			tok_out <= tok_next;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/max_xor_subset_basis_core.sv -----
// Top level of the maximum subset XOR core: a chain of basis cells and an output register.
// Path: an element enters the first cell's register at its own transfer and moves down
// through the WIDTH cells from the top bit down, advancing only while the output is not
// stalled; the tail then feeds the output register, which takes a set's result once its
// last element has passed every cell.
// Throughput: one element per cycle while not stalled; the chain sets this, one slot per cell.
// Reset clears every basis slot and every valid flag at once, so no clearing pass is needed.
`default_nettype none
module max_xor_subset_basis_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire mxb_pkg::field_t       s_tdata,   // [31:0] value
	input  wire logic                  s_tlast,   // marks the final element of a set
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output mxb_pkg::field_t            m_tdata    // [31:0] max_xor
);

	// Chain position k carries the token entering cell k; the last position is the tail.
	mxb_pkg::token_t tok [mxb_pkg::WIDTH+1];

	logic            adv;
	logic            out_valid_q;
	mxb_pkg::field_t out_data_q;

	// The whole chain moves together. It holds only while a result waits and the
	// downstream side is not taking it, so nothing inside the chain is ever dropped.
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	// The element entering the chain. Bits at or above WIDTH are dropped here.
	always_comb begin
		tok[0].valid = s_tvalid;
		tok[0].last  = s_tlast;
		tok[0].v     = mxb_pkg::field_to_row(s_tdata);
		tok[0].acc   = '0;
	end

	// Cell k owns basis slot WIDTH-1-k, so values are reduced from the top bit down.
	// A later element reaches each cell only after an earlier one has left it, which
	// keeps the insertion order of the sequential algorithm.
	for (genvar k = 0; k < mxb_pkg::WIDTH; k++) begin : g_cell
		mxb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.pos     (mxb_pkg::row_t'(1) << (mxb_pkg::WIDTH - 1 - k)),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	// Only the element that closed a set leaves a result behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tok[mxb_pkg::WIDTH].valid && tok[mxb_pkg::WIDTH].last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= mxb_pkg::row_to_field(tok[mxb_pkg::WIDTH].acc);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A stalled output must freeze the tail of the chain as well.
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(tok[mxb_pkg::WIDTH]))
		else $error("chain tail moved while the result was stalled");

	// A new result only follows a closing element at the tail.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tok[mxb_pkg::WIDTH].valid && tok[mxb_pkg::WIDTH].last))
		else $error("result raised without a closing element at the tail");

	// Every transfer on the input side enters the first cell.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> tok[1].valid)
		else $error("accepted element did not enter the chain");

endmodule
`default_nettype wire
